// ===== sv/n2r_pkg.sv =====
package n2r_pkg;

  // BT.601 studio-range coefficients, 8-bit fraction
  localparam int unsigned CoefY  = 298;
  localparam int unsigned CoefRv = 409;
  localparam int unsigned CoefGu = 100;
  localparam int unsigned CoefGv = 208;
  localparam int unsigned CoefBu = 516;

  localparam int unsigned Round     = 128;
  localparam int unsigned LumaOfs   = 16;
  localparam int unsigned ChromaOfs = 128;
  localparam logic [7:0]  AlphaOpaque = 8'd255;

  // width of the fixed-point channel sums
  localparam int unsigned SumW = 20;

  typedef logic signed [SumW-1:0] sum_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // floor shift by the fraction, then clamp to 0..255
  function automatic logic [7:0] sat8(sum_t s);
    logic [7:0] res;
    if (s[SumW-1]) begin
      res = 8'd0;
    end else if (|s[SumW-2:16]) begin
      res = 8'd255;
    end else begin
      res = s[15:8];
    end
    return res;
  endfunction

endpackage

// ===== sv/n2r_if.sv =====
// one NV12 pixel pair
interface n2r_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma_first;
  logic [7:0] luma_second;
  logic [7:0] chroma_u;
  logic [7:0] chroma_v;
  logic       start_of_frame;

  modport source (
    output valid, luma_first, luma_second, chroma_u, chroma_v, start_of_frame,
    input  ready
  );
  modport sink (
    input  valid, luma_first, luma_second, chroma_u, chroma_v, start_of_frame,
    output ready
  );
endinterface

// two RGBA pixels
interface n2r_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_first;
  logic [7:0] green_first;
  logic [7:0] blue_first;
  logic [7:0] red_second;
  logic [7:0] green_second;
  logic [7:0] blue_second;
  logic [7:0] alpha;
  logic       end_of_line;

  modport source (
    output valid, red_first, green_first, blue_first, red_second, green_second,
           blue_second, alpha, end_of_line,
    input  ready
  );
  modport sink (
    input  valid, red_first, green_first, blue_first, red_second, green_second,
           blue_second, alpha, end_of_line,
    output ready
  );
endinterface

// ===== sv/n2r_pixel_conv.sv =====
// Two-stage YUV to RGB for one pixel: constant products, then sums and clamp.
module n2r_pixel_conv (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [7:0]        luma_i,
  input  logic signed [8:0] d_i,
  input  logic signed [8:0] e_i,
  output n2r_pkg::rgb_t     pix_o
);
  import n2r_pkg::*;

  logic [7:0] c;
  sum_t py_q, pre_q, pgd_q, pge_q, pbd_q;
  sum_t sr, sg, sb;
  rgb_t pix_q;

  // luma offset, clamped below at zero
  assign c = (luma_i < 8'(LumaOfs)) ? 8'd0 : (luma_i - 8'(LumaOfs));

  // stage A: one constant multiply per term
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      py_q  <= SumW'($signed({1'b0, c}) * $signed(CoefY));
      pre_q <= SumW'(e_i * $signed(CoefRv));
      pgd_q <= SumW'(d_i * $signed(CoefGu));
      pge_q <= SumW'(e_i * $signed(CoefGv));
      pbd_q <= SumW'(d_i * $signed(CoefBu));
    end
  end

  // stage B: sums with rounding
  assign sr = py_q + pre_q + sum_t'(Round);
  assign sg = py_q - pgd_q - pge_q + sum_t'(Round);
  assign sb = py_q + pbd_q + sum_t'(Round);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix_q.r <= sat8(sr);
      pix_q.g <= sat8(sg);
      pix_q.b <= sat8(sb);
    end
  end

  assign pix_o = pix_q;

endmodule

// ===== sv/nv12_to_rgba_converter.sv =====
// NV12 to RGBA, one pixel pair per beat.
// Pipeline: line store read, products, sums, each registered, from input beat to output beat.
// Throughput: one pair per cycle; the whole pipeline stalls only while the
// output register holds a beat that is not taken.
// Reset: row position, row parity and valids clear, pairs_cfg_q returns to 960;
// the chroma line store is not cleared and is valid only where an even row wrote it.
module nv12_to_rgba_converter #(
  parameter int unsigned MAX_PAIRS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  n2r_in_if.sink      pix_in_i,
  n2r_out_if.source   pix_out_o
);
  import n2r_pkg::*;

  localparam int unsigned AW  = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int unsigned CW  = $clog2(MAX_PAIRS + 1);
  localparam int unsigned PW  = (CW > 11) ? CW : 11;

  logic [10:0]   pairs_cfg_q;
  logic [AW-1:0] col_q, col_d;
  logic          odd_q, odd_d;

  logic [PW-1:0] cfg_ext, pairs, pairs_m1;
  logic [AW-1:0] col_base, col_cur;
  logic          odd_cur, last;
  logic          en, accept;

  // chroma line store, U high byte, V low byte
  logic [15:0]   line_mem [MAX_PAIRS];
  logic [15:0]   rd_q;

  logic          s1_v_q, s2_v_q, out_v_q;
  logic [7:0]    s1_y0_q, s1_y1_q, s1_u_q, s1_v_byte_q;
  logic          s1_odd_q, s1_eol_q, s2_eol_q, out_eol_q;
  logic [7:0]    u_sel, v_sel;
  logic signed [8:0] d, e;
  rgb_t          pix0, pix1;

  // global advance: output register empty or being drained
  assign en     = !out_v_q || pix_out_o.ready;
  assign accept = pix_in_i.valid && en;
  assign pix_in_i.ready = en;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pairs_cfg_q <= 11'd960;
    end else if (cfg_we_i) begin
      pairs_cfg_q <= cfg_wdata_i;
    end
  end

  // effective width, clamped to 1..MAX_PAIRS
  assign cfg_ext = PW'(pairs_cfg_q);
  always_comb begin
    priority if (cfg_ext == '0) begin
      pairs = PW'(1);
    end else if (cfg_ext > PW'(MAX_PAIRS)) begin
      pairs = PW'(MAX_PAIRS);
    end else begin
      pairs = cfg_ext;
    end
  end
  assign pairs_m1 = pairs - PW'(1);

  // position of the current beat
  assign col_base = pix_in_i.start_of_frame ? '0 : col_q;
  assign odd_cur  = pix_in_i.start_of_frame ? 1'b0 : odd_q;
  assign col_cur  = (PW'(col_base) >= pairs) ? AW'(pairs_m1) : col_base;
  assign last     = (PW'(col_cur) == pairs_m1);
  assign col_d    = last ? '0 : (col_cur + AW'(1));
  assign odd_d    = last ? !odd_cur : odd_cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      odd_q <= 1'b0;
    end else if (accept) begin
      col_q <= col_d;
      odd_q <= odd_d;
    end
  end

  // line store: even rows write, odd rows read (a row apart, no overlap)
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (!odd_cur) begin
        line_mem[col_cur] <= {pix_in_i.chroma_u, pix_in_i.chroma_v};
      end else begin
        rd_q <= line_mem[col_cur];
      end
    end
  end

  // stage 1 payload, plus the end-of-line flag chain
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_y0_q     <= pix_in_i.luma_first;
      s1_y1_q     <= pix_in_i.luma_second;
      s1_u_q      <= pix_in_i.chroma_u;
      s1_v_byte_q <= pix_in_i.chroma_v;
      s1_odd_q    <= odd_cur;
      s1_eol_q    <= last;
      s2_eol_q    <= s1_eol_q;
      out_eol_q   <= s2_eol_q;
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q  <= pix_in_i.valid;
      s2_v_q  <= s1_v_q;
      out_v_q <= s2_v_q;
    end
  end

  // chroma source: this beat on even rows, line store on odd rows
  assign u_sel = s1_odd_q ? rd_q[15:8] : s1_u_q;
  assign v_sel = s1_odd_q ? rd_q[7:0]  : s1_v_byte_q;
  assign d = $signed({1'b0, u_sel}) - $signed(9'(ChromaOfs));
  assign e = $signed({1'b0, v_sel}) - $signed(9'(ChromaOfs));

  n2r_pixel_conv u_conv_first (
    .clk_i  (clk_i),
    .en_i   (en),
    .luma_i (s1_y0_q),
    .d_i    (d),
    .e_i    (e),
    .pix_o  (pix0)
  );

  n2r_pixel_conv u_conv_second (
    .clk_i  (clk_i),
    .en_i   (en),
    .luma_i (s1_y1_q),
    .d_i    (d),
    .e_i    (e),
    .pix_o  (pix1)
  );

  assign pix_out_o.valid        = out_v_q;
  assign pix_out_o.red_first    = pix0.r;
  assign pix_out_o.green_first  = pix0.g;
  assign pix_out_o.blue_first   = pix0.b;
  assign pix_out_o.red_second   = pix1.r;
  assign pix_out_o.green_second = pix1.g;
  assign pix_out_o.blue_second  = pix1.b;
  assign pix_out_o.alpha        = AlphaOpaque;
  assign pix_out_o.end_of_line  = out_eol_q;

  // last pair of a row wraps the column and flips parity
  a_eol_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last) |=> (col_q == '0 && odd_q == !$past(odd_cur)))
    else $error("row wrap failed");

  // inside a row the column steps by one and parity holds
  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !last) |=> (col_q == $past(col_cur) + AW'(1) && odd_q == $past(odd_cur)))
    else $error("column step failed");

  // an accepted beat reaches stage 1
  a_s1_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_v_q)
    else $error("accepted beat lost");

  // a moving stage 2 beat lands in the output register
  a_out_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && s2_v_q) |=> out_v_q)
    else $error("stage 2 beat lost");

  // a stalled output beat keeps its end-of-line flag
  a_hold_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !pix_out_o.ready) |=> (out_v_q && $stable(out_eol_q)))
    else $error("stalled beat changed");

endmodule
